// ===== sv/iprct_pkg.sv =====
// Package with types, widths and status codes of the IP rate count table.
package iprct_pkg;
  localparam int unsigned BinBitsDefault = 10;
  localparam int unsigned WaysDefault = 4;
  localparam logic [31:0] WindowReset = 32'd60;

  typedef enum logic [1:0] {
    OP_ACCESS = 2'd0,
    OP_REMOVE = 2'd1,
    OP_SET    = 2'd2,
    OP_UNUSED = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic        domain;
    logic [63:0] key_high;
    logic [63:0] key_low;
    logic [31:0] new_count;
    logic [31:0] req_time;
  } request_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] count;
  } result_t;

  typedef struct packed {
    logic        valid;
    logic        family;
    logic [127:0] address;
    logic [31:0] count;
    logic [31:0] stamp;
  } entry_t;
endpackage

// ===== sv/iprct_if.sv =====
// Valid/ready channel interface carrying one payload of a given type.
interface iprct_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== sv/ip_rate_count_table.sv =====
// Hashed table of IPv4/IPv6 addresses with per-address windowed access counts.
//
// Requests arrive on req (opcode, domain, key_high, key_low, new_count,
// req_time) and each produces exactly one result on rsp (status, count).
// The cfg channel writes the 32-bit window length; it is always ready.
// A request selects a bin and its ways are scanned in turn through a single
// memory read port and one key comparator, each way read and then compared;
// afterwards the updated entry is written back while the result is loaded into
// the output register. A new request is accepted only in the idle state,
// after the previous one has been written back.
// After reset the table is cleared by a pass that writes one entry per cycle,
// and req.ready stays low until all 2^BIN_BITS * WAYS entries (4096 by
// default) are cleared; the window length is loaded with 60.
// When the receiver stalls, the result stays in its register; one more
// request can be accepted and scanned, and it then waits before write-back
// until the output register is free.
module ip_rate_count_table #(
  parameter int unsigned BIN_BITS = iprct_pkg::BinBitsDefault,
  parameter int unsigned WAYS = iprct_pkg::WaysDefault
) (
  input logic clk,
  input logic rst,
  iprct_if.sink req,
  iprct_if.source rsp,
  iprct_if.sink cfg
);
  import iprct_pkg::*;

  localparam int unsigned WayBits = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned Depth = (1 << BIN_BITS) * WAYS;
  localparam int unsigned AddrBits = $clog2(Depth);

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_READ, S_CMP, S_WRITE} state_t;

  state_t state;
  request_t cur;
  logic [31:0] window_length;
  entry_t mem [Depth];
  entry_t rd_data;
  logic [AddrBits-1:0] base;
  logic [WayBits-1:0] way;
  logic [WayBits-1:0] hit_way;
  logic [WayBits-1:0] free_way;
  logic found;
  logic have_free;
  entry_t hit_entry;
  result_t out_reg;
  result_t out_next;
  logic out_valid;
  logic load_out;
  logic [BIN_BITS-1:0] bin;
  logic [127:0] key;
  logic [AddrBits-1:0] rd_addr;
  logic [AddrBits-1:0] clr_addr;
  logic match;
  logic [32:0] limit;
  logic wr_en;
  logic [AddrBits-1:0] wr_addr;
  entry_t wr_data;
  logic last_way;

  always_comb begin
    if (req.payload.domain == 1'b0) begin
      bin = BIN_BITS'(req.payload.key_low[31:16]);
    end else begin
      bin = BIN_BITS'(req.payload.key_low[15:0]);
    end
  end

  assign key = cur.domain ? {cur.key_high, cur.key_low} : {96'd0, cur.key_low[31:0]};
  assign rd_addr = base + AddrBits'(way);
  assign match = rd_data.valid && rd_data.family == cur.domain &&
                 rd_data.address == key;
  assign limit = {1'b0, hit_entry.stamp} + {1'b0, window_length};
  assign last_way = (32'(way) == WAYS - 1);
  assign load_out = (state == S_WRITE) && (!out_valid || rsp.ready);
  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign rsp.valid = out_valid;
  assign rsp.payload = out_reg;

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_comb begin
    wr_en = 1'b0;
    wr_addr = base + AddrBits'(found ? hit_way : free_way);
    wr_data = hit_entry;
    out_next.status = ST_NOT_FOUND;
    out_next.count = 32'd0;
    if (state == S_CLEAR) begin
      wr_en = 1'b1;
      wr_addr = clr_addr;
      wr_data = '0;
    end else begin
      unique case (cur.opcode)
        OP_ACCESS: begin
          if (found) begin
            wr_en = load_out;
            if (limit < {1'b0, cur.req_time}) begin
              wr_data.count = 32'd1;
              wr_data.stamp = cur.req_time;
            end else if (hit_entry.count != 32'hFFFFFFFF) begin
              wr_data.count = hit_entry.count + 32'd1;
            end
            out_next.status = ST_OK;
            out_next.count = wr_data.count;
          end else if (have_free) begin
            wr_en = load_out;
            wr_data.valid = 1'b1;
            wr_data.family = cur.domain;
            wr_data.address = key;
            wr_data.count = 32'd1;
            wr_data.stamp = cur.req_time;
            out_next.status = ST_OK;
            out_next.count = 32'd1;
          end else begin
            out_next.status = ST_FULL;
          end
        end
        OP_REMOVE: begin
          if (found) begin
            wr_en = load_out;
            wr_data.valid = 1'b0;
            out_next.status = ST_OK;
            out_next.count = hit_entry.count;
          end
        end
        OP_SET: begin
          if (found) begin
            wr_en = load_out;
            wr_data.count = cur.new_count;
            wr_data.stamp = cur.req_time;
            out_next.status = ST_OK;
            out_next.count = hit_entry.count;
          end
        end
        default: begin
          wr_en = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_addr <= '0;
      out_valid <= 1'b0;
      window_length <= WindowReset;
      way <= '0;
    end else begin
      if (cfg.valid) begin
        window_length <= cfg.payload;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          if (clr_addr == AddrBits'(Depth - 1)) begin
            state <= S_IDLE;
          end else begin
            clr_addr <= clr_addr + AddrBits'(1);
          end
        end
        S_IDLE: begin
          if (req.valid && req.ready) begin
            cur <= req.payload;
            base <= AddrBits'(32'(bin) * WAYS);
            way <= '0;
            found <= 1'b0;
            have_free <= 1'b0;
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_CMP;
        end
        S_CMP: begin
          if (match && !found) begin
            found <= 1'b1;
            hit_way <= way;
            hit_entry <= rd_data;
          end else if (!rd_data.valid && !have_free) begin
            have_free <= 1'b1;
            free_way <= way;
          end
          if (last_way) begin
            state <= S_WRITE;
          end else begin
            way <= way + WayBits'(1);
            state <= S_READ;
          end
        end
        S_WRITE: begin
          if (load_out) begin
            out_reg <= out_next;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end
endmodule
